// ===== src/sdpf_pkg.sv =====
// sdpf_pkg: shared types and constants for the step/direction position follower
// used by sdpf_cfg, sdpf_core and step_dir_position_follower
`timescale 1ns / 1ps

package sdpf_pkg;

  localparam int unsigned ScaleW    = 12;
  localparam int unsigned PosW      = 24;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 2 * ByteW;
  localparam int unsigned FracBits  = 4;
  localparam int unsigned ProdW     = WordW + ScaleW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = ScaleW;
  localparam int unsigned OutDataW  = 32;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(3625);

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegScale     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegAckEnable = CfgIdxW'(1);

  // input item kinds
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic              ack_enable;
  } cfg_t;

  typedef struct packed {
    logic             command;
    logic [ByteW-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            ack;
    logic            direction;
    logic            step_pulse;
  } res_item_t;

endpackage

// ===== src/sdpf_cfg.sv =====
// sdpf_cfg: configuration registers (scale, ack enable) behind the write channel
// depends on sdpf_pkg
`timescale 1ns / 1ps

module sdpf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdpf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sdpf_pkg::CfgDataW-1:0]  cfg_data_i,
  output sdpf_pkg::cfg_t                 cfg_o
);
  import sdpf_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        RegScale:     cfg_d.scale      = cfg_data_i;
        RegAckEnable: cfg_d.ack_enable = cfg_data_i[0];
        default:      cfg_d = cfg_q; // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale      <= ScaleReset;
      cfg_q.ack_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/sdpf_core.sv =====
// sdpf_core: byte pairing, target scaling and the position step logic
// holds the follower state; depends on sdpf_pkg
`timescale 1ns / 1ps

module sdpf_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  sdpf_pkg::in_item_t    item_i,
  input  sdpf_pkg::cfg_t        cfg_i,
  output sdpf_pkg::res_item_t   res_o
);
  import sdpf_pkg::*;

  logic              pending_q, pending_d;
  logic [ByteW-1:0]  high_q, high_d;
  logic [PosW-1:0]   target_q, target_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              dir_q, dir_d;

  logic [WordW-1:0]  word;
  logic [ProdW-1:0]  prod;
  logic              step;
  logic              ack;

  assign word = {high_q, item_i.rx_byte};
  assign prod = ProdW'(word) * ProdW'(cfg_i.scale);

  always_comb begin
    pending_d = pending_q;
    high_d    = high_q;
    target_d  = target_q;
    pos_d     = pos_q;
    dir_d     = dir_q;
    step      = 1'b0;
    ack       = 1'b0;
    case (item_i.command)
      CmdByte: begin
        if (pending_q) begin
          // floor of word * scale / 16
          target_d  = prod[FracBits +: PosW];
          pending_d = 1'b0;
          ack       = cfg_i.ack_enable;
        end else begin
          high_d    = item_i.rx_byte;
          pending_d = 1'b1;
        end
      end
      CmdTick: begin
        if (pos_q < target_q) begin
          pos_d = pos_q + PosW'(1);
          dir_d = 1'b0;
          step  = 1'b1;
        end else if (pos_q > target_q) begin
          pos_d = pos_q - PosW'(1);
          dir_d = 1'b1;
          step  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      high_q    <= '0;
      target_q  <= '0;
      pos_q     <= '0;
      dir_q     <= 1'b0;
    end else if (advance_i) begin
      pending_q <= pending_d;
      high_q    <= high_d;
      target_q  <= target_d;
      pos_q     <= pos_d;
      dir_q     <= dir_d;
    end
  end

  assign res_o.step_pulse = step;
  assign res_o.direction  = dir_d;
  assign res_o.ack        = ack;
  assign res_o.position   = pos_d;

endmodule

// ===== src/step_dir_position_follower.sv =====
// step_dir_position_follower: top level, input register, core and result register
// depends on sdpf_pkg, sdpf_cfg and sdpf_core
//
// channel   direction  signals                          content
// s_axis    in         tvalid tready tdata[7:0] tuser   received byte / tick flag
// m_axis    out        tvalid tready tdata[31:0]        step, dir, ack, position
// cfg       in         valid ready index data           scale, ack enable
//
// one item per cycle while m_axis is not stalled; an item's result reaches m_axis
// via input register then result register, the compare and step between them
// control state clears on reset: target and position 0, scale 3625, ack on
// a stalled m_axis holds the result; s_axis keeps accepting while a stage is free
`timescale 1ns / 1ps

module step_dir_position_follower (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  input  logic                           s_axis_tuser,  // [0] command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] step_pulse, [1] direction, [2] ack, [26:3] position, [31:27] zero
  output logic [sdpf_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdpf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sdpf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sdpf_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  res_item_t res_comb;
  res_item_t res_q;
  logic      out_valid_q;
  logic      out_free;
  logic      advance;
  logic      in_take;

  sdpf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign advance       = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.command <= s_axis_tuser;
      in_q.rx_byte <= s_axis_tdata;
    end
  end

  sdpf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(res_q);

endmodule
